>>> hw/rtl/cmvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_pkg: shared constants for the complex matrix-vector multiply unit
// Field widths, operation and register codes, and default sizes.
// ----------------------------------------------------------------------------
package cmvm_pkg;

  // Default parameter values.
  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_ELEM_WIDTH = 16;

  // Fixed field widths.
  localparam int IDX_W     = 4;
  localparam int SUM_W     = 40;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Operation codes of an input item.
  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // Product modes.
  localparam logic MODE_MV = 1'b0;
  localparam logic MODE_VM = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 2'd2;

  // Reset value of the size registers.
  localparam logic [CNT_W-1:0] SIZE_RESET = 5'd16;

endpackage

>>> hw/rtl/cmvm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_in_if: load channel of the complex matrix-vector multiply unit
// Carries one matrix or vector entry per item.
// ----------------------------------------------------------------------------
interface cmvm_in_if
  import cmvm_pkg::*;
#(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [IDX_W-1:0]             row_index;
  logic [IDX_W-1:0]             col_index;
  logic signed [ELEM_WIDTH-1:0] value_re;
  logic signed [ELEM_WIDTH-1:0] value_im;
  logic                         last_element;

  modport source (output valid, op, row_index, col_index, value_re, value_im,
                  last_element, input ready);
  modport sink   (input valid, op, row_index, col_index, value_re, value_im,
                  last_element, output ready);
endinterface

>>> hw/rtl/cmvm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_out_if: result channel of the complex matrix-vector multiply unit
// Carries one complex sum per item.
// ----------------------------------------------------------------------------
interface cmvm_out_if
  import cmvm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;
  logic                    last_result;

  modport source (output valid, out_index, sum_re, sum_im, last_result, input ready);
  modport sink   (input valid, out_index, sum_re, sum_im, last_result, output ready);
endinterface

>>> hw/rtl/cmvm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_cfg_if: configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface cmvm_cfg_if
  import cmvm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/complex_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply_unit: complex M*v / v*M product engine
// Loads complex Q1.15 entries into a matrix memory and a vector memory and,
// on the vector item marked last, streams out one 40-bit complex sum, kept
// modulo 2^40, per row (M*v) or per column (v*M).
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  in_ch    in   valid / ready  op, row_index, col_index, value_re/im, last_element
//  out_ch   out  valid / ready  out_index, sum_re/im, last_result
//  cfg_ch   in   valid / ready  index, data (product_mode, row_count, col_count)
//
// Load items are taken while idle. The vector item marked last starts a product
// that holds the load channel closed while it runs, one multiply-accumulate
// step per cycle unless the output stalls, bounded by the single read port of
// the matrix memory. After its last step, a sum passes the read, partial-product
// and output registers. Reset is synchronous and active low; it sets the
// registers to their defaults and does not clear the memories.
// A full output register that is not taken stalls the whole read pipeline.
//
module complex_matrix_vector_multiply_unit
  import cmvm_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  cmvm_in_if.sink       in_ch,
  cmvm_out_if.source    out_ch,
  cmvm_cfg_if.sink      cfg_ch
);

  // Sizes derived from the parameters.
  localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int VA_W      = $clog2(MAX_DIM);
  localparam int MA_W      = $clog2(MAX_ROWS * MAX_COLS);
  localparam int SZ_W      = $clog2(MAX_DIM + 1);
  localparam int CMP_W     = (SZ_W > CNT_W) ? SZ_W : CNT_W;
  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int EW2       = 2 * ELEM_WIDTH;
  localparam int TW        = (EW2 + 1 > SUM_W) ? EW2 + 1 : SUM_W;

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration registers.
  logic             mode_r;
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] col_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MV;
      row_count_r <= SIZE_RESET;
      col_count_r <= SIZE_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_PRODUCT_MODE: mode_r      <= cfg_ch.data[0];
        CFG_ROW_COUNT:    row_count_r <= cfg_ch.data;
        CFG_COL_COUNT:    col_count_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Effective sizes: zero acts as one, anything above the maximum as the maximum.
  logic [CMP_W-1:0] rows_eff, cols_eff, vlen, outer;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(row_count_r) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(col_count_r) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(col_count_r);
    end
    vlen  = (mode_r == MODE_VM) ? rows_eff : cols_eff;
    outer = (mode_r == MODE_VM) ? cols_eff : rows_eff;
  end

  // Sequencer and step counters.
  logic            state_r, state_nxt;
  logic [VA_W-1:0] j_r, j_nxt;
  logic [VA_W-1:0] k_r, k_nxt;
  logic            adv;
  logic            in_acc;
  logic            start;
  logic            j_last, k_last;

  // The pipeline moves whenever the output register can take a new sum.
  assign adv    = !out_ch.valid || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign start  = in_acc && (in_ch.op == OP_VECTOR) && in_ch.last_element;
  assign j_last = (CMP_W'(j_r) == vlen - CMP_W'(1));
  assign k_last = (CMP_W'(k_r) == outer - CMP_W'(1));

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (j_last) begin
            j_nxt = '0;
            if (k_last) begin
              state_nxt = ST_IDLE;
            end else begin
              k_nxt = k_r + VA_W'(1);
            end
          end else begin
            j_nxt = j_r + VA_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Memory addressing. Loads write while idle; the product reads while running.
  logic            mat_we, vec_we;
  logic [MA_W-1:0] mat_waddr, mat_raddr;
  logic [VA_W-1:0] vec_waddr;
  logic [VA_W-1:0] rd_row, rd_col;
  logic            issue;

  assign mat_we = in_acc && (in_ch.op == OP_MATRIX)
                  && (CMP_W'(in_ch.row_index) < rows_eff)
                  && (CMP_W'(in_ch.col_index) < cols_eff);
  assign vec_we = in_acc && (in_ch.op == OP_VECTOR)
                  && (CMP_W'(in_ch.col_index) < vlen);
  assign mat_waddr = MA_W'(in_ch.row_index) * MA_W'(MAX_COLS) + MA_W'(in_ch.col_index);
  assign vec_waddr = VA_W'(in_ch.col_index);

  // M*v walks row k across columns j; v*M walks column k down rows j.
  assign rd_row    = (mode_r == MODE_VM) ? j_r : k_r;
  assign rd_col    = (mode_r == MODE_VM) ? k_r : j_r;
  assign mat_raddr = MA_W'(rd_row) * MA_W'(MAX_COLS) + MA_W'(rd_col);
  assign issue     = (state_r == ST_RUN);

  logic [EW2-1:0] mat_mem [MAT_DEPTH];
  logic [EW2-1:0] vec_mem [MAX_DIM];
  logic [EW2-1:0] mat_rd_r;
  logic [EW2-1:0] vec_rd_r;

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= {in_ch.value_re, in_ch.value_im};
    end
    if (adv && issue) begin
      mat_rd_r <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= {in_ch.value_re, in_ch.value_im};
    end
    if (adv && issue) begin
      vec_rd_r <= vec_mem[j_r];
    end
  end

  // Stage 1: read data valid. Tags follow each step down the pipeline.
  logic             s1_v_r, s1_first_r, s1_jlast_r, s1_klast_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r, s2_first_r, s2_jlast_r, s2_klast_r;
  logic [IDX_W-1:0] s2_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= (j_r == '0);
      s1_jlast_r <= j_last;
      s1_klast_r <= k_last;
      s1_idx_r   <= IDX_W'(k_r);
      s2_first_r <= s1_first_r;
      s2_jlast_r <= s1_jlast_r;
      s2_klast_r <= s1_klast_r;
      s2_idx_r   <= s1_idx_r;
    end
  end

  // Stage 2: the four partial products of one complex multiply.
  logic signed [ELEM_WIDTH-1:0] a_re, a_im, b_re, b_im;
  logic signed [EW2-1:0]        rr_r, ii_r, ri_r, ir_r;

  assign a_re = $signed(mat_rd_r[EW2-1:ELEM_WIDTH]);
  assign a_im = $signed(mat_rd_r[ELEM_WIDTH-1:0]);
  assign b_re = $signed(vec_rd_r[EW2-1:ELEM_WIDTH]);
  assign b_im = $signed(vec_rd_r[ELEM_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      rr_r <= a_re * b_re;
      ii_r <= a_im * b_im;
      ri_r <= a_re * b_im;
      ir_r <= a_im * b_re;
    end
  end

  // Stage 3: accumulate modulo 2^40; a finished sum goes to the output register.
  logic signed [TW-1:0]    t_re, t_im;
  logic signed [SUM_W-1:0] acc_re_r, acc_im_r;
  logic signed [SUM_W-1:0] acc_re_nxt, acc_im_nxt;
  logic signed [SUM_W-1:0] base_re, base_im;

  assign t_re       = TW'(rr_r) - TW'(ii_r);
  assign t_im       = TW'(ri_r) + TW'(ir_r);
  assign base_re    = s2_first_r ? '0 : acc_re_r;
  assign base_im    = s2_first_r ? '0 : acc_im_r;
  assign acc_re_nxt = base_re + $signed(t_re[SUM_W-1:0]);
  assign acc_im_nxt = base_im + $signed(t_im[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
  end

  // Output register.
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [SUM_W-1:0] sum_re_r, sum_im_r;
  logic                    last_result_r;
  logic                    out_load;

  assign out_load = adv && s2_v_r && s2_jlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r   <= s2_idx_r;
      sum_re_r      <= acc_re_nxt;
      sum_im_r      <= acc_im_nxt;
      last_result_r <= s2_klast_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_index   = out_index_r;
  assign out_ch.sum_re      = sum_re_r;
  assign out_ch.sum_im      = sum_im_r;
  assign out_ch.last_result = last_result_r;

endmodule

>>> hw/rtl/cmvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_checker: port-level checks for the complex matrix-vector multiply unit
// Watches the load and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cmvm_checker
  import cmvm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_op,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [IDX_W-1:0]        out_index,
  input logic signed [SUM_W-1:0] sum_re,
  input logic signed [SUM_W-1:0] sum_im
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sum_re) && $stable(sum_im) && $stable(out_index))
    else $error("result payload changed while stalled");

  // The item that starts a product closes the load channel in the next cycle.
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_VECTOR) && in_last |=> !in_ready)
    else $error("load channel open right after a product start");

  // A plain load keeps the load channel open.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !((in_op == OP_VECTOR) && in_last) |=> in_ready)
    else $error("load channel closed after a plain load");

endmodule

bind complex_matrix_vector_multiply_unit cmvm_checker u_cmvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .in_last   (in_ch.last_element),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .sum_re    (out_ch.sum_re),
  .sum_im    (out_ch.sum_im)
);

>>> tb/tb_complex_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_matrix_vector_multiply_unit: self-checking bench for the complex
// matrix-vector multiply unit.
// Fills both stores, runs directed corner products and then random phases of
// load sequences under random sizes and modes. A bench-side copy of the stores
// predicts every complex sum, and each sum leaving the unit is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_complex_matrix_vector_multiply_unit;
  import cmvm_pkg::*;

  localparam int MAX_ROWS     = DEF_MAX_ROWS;
  localparam int MAX_COLS     = DEF_MAX_COLS;
  localparam int ELEM_W       = DEF_ELEM_WIDTH;
  localparam int VEC_DEPTH    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  // Idle time after the last predicted sum; it also covers a matrix load that
  // is still being written.
  localparam int DRAIN_CYCLES = 8;
  // During a full 16 x 16 product the load channel stays closed, and pipeline
  // and sink stalls add quiet time. The limit lies well above that.
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_REPORTS  = 40;
  localparam int IDLE_PERCENT = 37;

  // Register index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  // One load item as it travels on the input channel.
  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] re;
    logic signed [ELEM_W-1:0] im;
    logic                     last;
  } entry_t;

  // One complex sum as it leaves the unit.
  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    last;
  } sum_t;

  logic clk;
  logic rst_n;

  cmvm_in_if #(.ELEM_WIDTH(ELEM_W)) load_ch ();
  cmvm_out_if                       sum_ch ();
  cmvm_cfg_if                       cfg_ch ();

  complex_matrix_vector_multiply_unit #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (load_ch),
    .out_ch (sum_ch),
    .cfg_ch (cfg_ch)
  );

  // Bench copy of the unit's state. The stores start unknown in hardware, so
  // the first test writes every entry before any product reads one.
  logic signed [ELEM_W-1:0] matrix_re [MAX_ROWS][MAX_COLS];
  logic signed [ELEM_W-1:0] matrix_im [MAX_ROWS][MAX_COLS];
  logic signed [ELEM_W-1:0] vector_re [VEC_DEPTH];
  logic signed [ELEM_W-1:0] vector_im [VEC_DEPTH];
  logic                     mode_q;
  logic [CNT_W-1:0]         rows_q;
  logic [CNT_W-1:0]         cols_q;

  sum_t expected_sums [$];

  int error_count;
  int items_sent;
  int items_used;
  int products_started;
  int sums_checked;
  int settings_applied;
  int quiet_cycles;
  bit steady;   // when set, neither side of the bench idles

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A size register of zero behaves as one, and values past the store depth
  // behave as the depth.
  function automatic int unsigned eff_size(logic [CNT_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Applies one accepted item to the bench stores and queues every sum that it
  // starts. Returns whether the item had any effect on the unit.
  function automatic bit predict_entry(entry_t e);
    int unsigned rows, cols, vlen, outer, k, j;
    longint acc_re, acc_im, a_re, a_im, b_re, b_im;
    sum_t s;
    bit used;
    rows  = eff_size(rows_q, MAX_ROWS);
    cols  = eff_size(cols_q, MAX_COLS);
    vlen  = (mode_q == MODE_VM) ? rows : cols;
    outer = (mode_q == MODE_VM) ? cols : rows;
    used  = 1'b0;
    if (e.op == OP_MATRIX) begin
      // The last mark has no meaning on a matrix load.
      if (e.row < rows && e.col < cols) begin
        matrix_re[e.row][e.col] = e.re;
        matrix_im[e.row][e.col] = e.im;
        used = 1'b1;
      end
      return used;
    end
    if (e.col < vlen) begin
      vector_re[e.col] = e.re;
      vector_im[e.col] = e.im;
      used = 1'b1;
    end
    // An out-of-range vector index is dropped, but the product still runs.
    if (!e.last) return used;
    products_started++;
    for (k = 0; k < outer; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (j = 0; j < vlen; j++) begin
        if (mode_q == MODE_VM) begin
          a_re = matrix_re[j][k];
          a_im = matrix_im[j][k];
        end else begin
          a_re = matrix_re[k][j];
          a_im = matrix_im[k][j];
        end
        b_re = vector_re[j];
        b_im = vector_im[j];
        acc_re += a_re * b_re - a_im * b_im;
        acc_im += a_re * b_im + a_im * b_re;
      end
      s.index = k[IDX_W-1:0];
      s.re    = acc_re[SUM_W-1:0];
      s.im    = acc_im[SUM_W-1:0];
      s.last  = (k + 1 == outer);
      expected_sums.push_back(s);
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  function automatic entry_t make_entry(logic op, int unsigned r, int unsigned c,
                                        logic signed [ELEM_W-1:0] re,
                                        logic signed [ELEM_W-1:0] im, logic last);
    entry_t e;
    e.op   = op;
    e.row  = r[IDX_W-1:0];
    e.col  = c[IDX_W-1:0];
    e.re   = re;
    e.im   = im;
    e.last = last;
    return e;
  endfunction

  // Element values lean on the extremes and zero, which stress the sums most.
  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Offers one item and holds it until the unit takes it. Valid is left high
  // so that the next item can follow in the very next cycle.
  task automatic send_item(input entry_t e);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      load_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    load_ch.valid        <= 1'b1;
    load_ch.op           <= e.op;
    load_ch.row_index    <= e.row;
    load_ch.col_index    <= e.col;
    load_ch.value_re     <= e.re;
    load_ch.value_im     <= e.im;
    load_ch.last_element <= e.last;
    do @(posedge clk); while (!load_ch.ready);
    items_sent++;
    if (predict_entry(e)) items_used++;
  endtask

  // Stops offering items, lets every predicted sum arrive and then gives the
  // unit time to finish any load that produces no sum.
  task automatic wait_until_idle();
    load_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_PRODUCT_MODE: mode_q = data[0];
      CFG_ROW_COUNT:    rows_q = data;
      CFG_COL_COUNT:    cols_q = data;
      default:          ;
    endcase
  endtask

  // Writes all three registers back to back while the unit is idle. The mode
  // write carries random upper data bits, which the unit must ignore.
  task automatic apply_settings(input logic mode, input logic [CNT_W-1:0] rows,
                                input logic [CNT_W-1:0] cols, input bit touch_spare);
    logic [CNT_W-2:0] pad;
    pad = (CNT_W-1)'($urandom);
    wait_until_idle();
    write_register(CFG_PRODUCT_MODE, {pad, mode});
    write_register(CFG_ROW_COUNT, rows);
    write_register(CFG_COL_COUNT, cols);
    if (touch_spare) write_register(CFG_SPARE, CNT_W'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [SUM_W-1:0] got,
                               input logic [SUM_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("sum %0d %s: got %0h, expected %0h",
                                sums_checked, name, got, want));
  endtask

  always @(posedge clk) begin : check_sums
    sum_t want;
    if (rst_n && sum_ch.valid && sum_ch.ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("sum for index %0d arrived with none expected",
                                  sum_ch.out_index));
      end else begin
        want = expected_sums.pop_front();
        compare_field("out_index", SUM_W'(sum_ch.out_index), SUM_W'(want.index));
        compare_field("sum_re", sum_ch.sum_re, want.re);
        compare_field("sum_im", sum_ch.sum_im, want.im);
        compare_field("last_result", SUM_W'(sum_ch.last_result), SUM_W'(want.last));
      end
      sums_checked++;
    end
  end

  // The result side stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    sum_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: any handshake restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (load_ch.valid && load_ch.ready) || (sum_ch.valid && sum_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb_complex_matrix_vector_multiply_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Writes every matrix and vector entry under the reset sizes, with the
  // extremes placed in the first two entries and the last one, and runs a full
  // M*v product on the reset register values.
  task automatic test_fill_stores();
    int unsigned r, c;
    logic signed [ELEM_W-1:0] re, im;
    for (r = 0; r < MAX_ROWS; r++) begin
      for (c = 0; c < MAX_COLS; c++) begin
        re = pick_value();
        im = pick_value();
        if (r == 0 && c == 0) begin
          re = ELEM_MIN;
          im = ELEM_MIN;
        end else if (r == 0 && c == 1) begin
          re = ELEM_MAX;
          im = ELEM_MAX;
        end else if (r == MAX_ROWS - 1 && c == MAX_COLS - 1) begin
          re = ELEM_MAX;
          im = ELEM_MIN;
        end
        send_item(make_entry(OP_MATRIX, r, c, re, im, 1'b0));
      end
    end
    send_item(make_entry(OP_VECTOR, 0, 0, ELEM_MIN, ELEM_MIN, 1'b0));
    send_item(make_entry(OP_VECTOR, 0, 1, ELEM_MAX, ELEM_MAX, 1'b0));
    for (c = 2; c < VEC_DEPTH; c++)
      send_item(make_entry(OP_VECTOR, 0, c, pick_value(), pick_value(), c == VEC_DEPTH - 1));
  endtask

  // One-by-one products: a zero size acting as one, loads outside the size,
  // a last mark on a matrix load, an out-of-range last vector item and a
  // product with no imaginary parts.
  task automatic test_size_corners();
    logic signed [ELEM_W-1:0] re;
    apply_settings(MODE_MV, '0, '0, 1'b1);
    // Ignored as a trigger; it only writes the single entry in use.
    send_item(make_entry(OP_MATRIX, 0, 0, ELEM_MIN, ELEM_MIN, 1'b1));
    send_item(make_entry(OP_MATRIX, 3, 5, pick_value(), pick_value(), 1'b0));
    send_item(make_entry(OP_MATRIX, 15, 0, pick_value(), pick_value(), 1'b0));
    send_item(make_entry(OP_VECTOR, 9, 0, ELEM_MIN, ELEM_MIN, 1'b1));
    send_item(make_entry(OP_VECTOR, 0, 7, pick_value(), pick_value(), 1'b1));
    send_item(make_entry(OP_VECTOR, 0, 0, ELEM_MAX, ELEM_MIN, 1'b1));
    send_item(make_entry(OP_VECTOR, 0, 15, ELEM_MAX, ELEM_MAX, 1'b1));
    // Real-only operands.
    re = pick_value();
    send_item(make_entry(OP_MATRIX, 0, 0, ELEM_MAX, '0, 1'b0));
    send_item(make_entry(OP_VECTOR, 0, 0, re, '0, 1'b1));
    send_item(make_entry(OP_VECTOR, 0, 0, ELEM_MIN, '0, 1'b1));
  endtask

  // Tall, wide and full shapes in both modes. The stores still hold entries
  // from the fill, so growing the size reuses them.
  task automatic test_large_shapes();
    apply_settings(MODE_VM, 5'd31, 5'd17, 1'b0);
    send_item(make_entry(OP_VECTOR, 0, 3, pick_value(), pick_value(), 1'b1));
    apply_settings(MODE_MV, 5'd16, 5'd1, 1'b0);
    send_item(make_entry(OP_VECTOR, 0, 0, ELEM_MAX, ELEM_MAX, 1'b1));
    apply_settings(MODE_VM, 5'd1, 5'd16, 1'b0);
    send_item(make_entry(OP_MATRIX, 0, 15, ELEM_MIN, ELEM_MAX, 1'b0));
    send_item(make_entry(OP_VECTOR, 0, 0, ELEM_MIN, ELEM_MIN, 1'b1));
    apply_settings(MODE_VM, 5'd16, 5'd16, 1'b0);
    send_item(make_entry(OP_VECTOR, 0, 15, pick_value(), pick_value(), 1'b1));
  endtask

  // A well-formed product: a few matrix loads, then vector loads (in order for
  // short vectors), the last one marked last. A few indices stray out of range.
  task automatic send_product_sequence();
    int unsigned rows, cols, vlen, r, c, j;
    bit real_only;
    rows      = eff_size(rows_q, MAX_ROWS);
    cols      = eff_size(cols_q, MAX_COLS);
    vlen      = (mode_q == MODE_VM) ? rows : cols;
    real_only = ($urandom_range(5) == 0);
    repeat ($urandom_range(0, 6)) begin
      r = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(rows - 1);
      c = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(cols - 1);
      send_item(make_entry(OP_MATRIX, r, c, pick_value(),
                           real_only ? '0 : pick_value(), $urandom_range(7) == 0));
    end
    if (vlen <= 4) begin
      for (j = 0; j + 1 < vlen; j++)
        send_item(make_entry(OP_VECTOR, $urandom_range(15), j, pick_value(),
                             real_only ? '0 : pick_value(), 1'b0));
    end else begin
      repeat (3)
        send_item(make_entry(OP_VECTOR, $urandom_range(15), $urandom_range(vlen - 2),
                             pick_value(), real_only ? '0 : pick_value(), 1'b0));
    end
    j = ($urandom_range(7) == 0) ? $urandom_range(15) : vlen - 1;
    send_item(make_entry(OP_VECTOR, $urandom_range(15), j, pick_value(),
                         real_only ? '0 : pick_value(), 1'b1));
  endtask

  // Arbitrary items, any index and any last mark.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item(make_entry($urandom_range(1) ? OP_VECTOR : OP_MATRIX, $urandom_range(15),
                           $urandom_range(15), pick_value(), pick_value(),
                           $urandom_range(3) == 0));
  endtask

  // Random phases. Most phases use small sizes so products stay short; now
  // and then any 5-bit size value is written. One phase runs with no idling.
  task automatic test_random_phases();
    int phase, first_used, n_seq;
    logic [CNT_W-1:0] r_cfg, c_cfg;
    phase      = 0;
    first_used = items_used;
    while (items_used - first_used < RANDOM_ITEMS) begin
      if ($urandom_range(5) == 0) begin
        r_cfg = CNT_W'($urandom);
        c_cfg = CNT_W'($urandom);
      end else begin
        r_cfg = CNT_W'($urandom_range(1, 4));
        c_cfg = CNT_W'($urandom_range(1, 4));
      end
      apply_settings($urandom_range(1) ? MODE_VM : MODE_MV, r_cfg, c_cfg,
                     $urandom_range(7) == 0);
      steady = (phase == 3);
      n_seq  = steady ? 10 : $urandom_range(2, 5);
      repeat (n_seq) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_product_sequence();
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count      = 0;
    items_sent       = 0;
    items_used       = 0;
    products_started = 0;
    sums_checked     = 0;
    settings_applied = 0;
    steady           = 1'b0;
    mode_q           = MODE_MV;
    rows_q           = SIZE_RESET;
    cols_q           = SIZE_RESET;

    // Every input starts at a known value; reset is held for a fixed count.
    rst_n                <= 1'b0;
    load_ch.valid        <= 1'b0;
    load_ch.op           <= OP_MATRIX;
    load_ch.row_index    <= '0;
    load_ch.col_index    <= '0;
    load_ch.value_re     <= '0;
    load_ch.value_im     <= '0;
    load_ch.last_element <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_PRODUCT_MODE;
    cfg_ch.data          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_stores();
    test_size_corners();
    test_large_shapes();
    test_random_phases();

    wait_until_idle();
    $display("Ran %0d load items (%0d with effect), %0d products, %0d checked sums.",
             items_sent, items_used, products_started, sums_checked);
    $display("Covered %0d register settings in both modes, sizes from 1x1 to 16x16.",
             settings_applied);
    if (error_count == 0) begin
      $display("tb_complex_matrix_vector_multiply_unit passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_complex_matrix_vector_multiply_unit failed");
    end
    $finish;
  end

endmodule
